@@ rtl/mf5_pkg.sv @@
// shared constants for the five-tap median filter with mirrored record edges
// no dependencies
package mf5_pkg;

  localparam int WIN_TAPS   = 5;
  localparam int WIN_HALF   = 2;
  localparam int HIST_DEPTH = 4;

  // seen count saturates at the history depth
  localparam int COUNT_BITS = 3;
  // window position within the known samples, 0 .. HIST_DEPTH
  localparam int POS_BITS   = 3;
  // results still owed by one item, 0 .. WIN_HALF + 1
  localparam int NRES_BITS  = 2;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [POS_BITS-1:0]   pos_t;
  typedef logic [NRES_BITS-1:0]  nres_t;

endpackage

@@ rtl/mf5_if.sv @@
// stream interfaces for the median filter: sample channel and result channel
// no dependencies
interface mf5_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          last_sample;

  modport source (output valid, output sample_in, output last_sample, input ready);
  modport sink   (input valid, input sample_in, input last_sample, output ready);
endinterface

interface mf5_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] median_out;
  logic                          last_result;

  modport source (output valid, output median_out, output last_result, input ready);
  modport sink   (input valid, input median_out, input last_result, output ready);
endinterface

@@ rtl/median5_filter_mirror_edges.sv @@
// five-tap running median filter with mirrored edges, top level
// depends on mf5_pkg and the stream interfaces in mf5_if
//
//   channel   | direction | payload                   | handshake
//   ----------+-----------+---------------------------+-------------
//   sample_i  | in        | sample_in, last_sample    | valid/ready
//   result_o  | out       | median_out, last_result   | valid/ready
//
// a sample that yields at most one result leaves the window register with it;
// the last sample of a record yields up to three results, issued one a cycle from
// the window register unless the output stalls, and holds it until the final result
// a sample is held in the window register and its result in the result register
// rst_ni clears the seen count and all valid flags; history needs no reset
// a stalled result register backs up into the window register and then the input
module median5_filter_mirror_edges
  import mf5_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  mf5_in_if.sink           sample_i,
  mf5_out_if.source        result_o
);

  typedef logic signed [SAMPLE_BITS-1:0] smp_t;

  // running history, entry 0 most recent
  smp_t   hist_q [HIST_DEPTH];
  count_t count_q;

  // window register: known samples of the record, oldest first, newest at top_q
  logic   win_valid_q;
  smp_t   buf_q  [HIST_DEPTH+1];
  pos_t   top_q;
  logic   last_q;
  nres_t  idx_q;

  // result register
  logic   out_valid_q;
  smp_t   median_q;
  logic   last_res_q;

  logic   in_fire;
  pos_t   k_in;
  smp_t   buf_d [HIST_DEPTH+1];

  nres_t  n_res;
  pos_t   base;
  pos_t   centre;
  smp_t   taps [WIN_TAPS];
  smp_t   median;
  logic   advance;
  logic   win_done;

  // mirror a window offset into the known samples 0 .. top
  function automatic pos_t tap_index(input pos_t c, input int d, input pos_t top);
    int j;
    int t;
    t = int'(top);
    j = int'(c) + d - WIN_HALF;
    if (j < 0) j = -j - 1;
    if (j > t) j = 2 * t + 1 - j;
    if (j < 0) j = 0;
    if (j > t) j = t;
    return pos_t'(j);
  endfunction

  assign in_fire = sample_i.valid && sample_i.ready;

  // saturated count gives the position of the new sample
  assign k_in = (int'(count_q) > HIST_DEPTH) ? pos_t'(HIST_DEPTH) : pos_t'(count_q);

  // lay the record out oldest first, positions above the new sample unused
  always_comb begin
    for (int p = 0; p <= HIST_DEPTH; p++) begin
      if (p == int'(k_in)) begin
        buf_d[p] = sample_i.sample_in;
      end else if (p < int'(k_in)) begin
        buf_d[p] = hist_q[2'(int'(k_in) - 1 - p)];
      end else begin
        buf_d[p] = sample_i.sample_in;
      end
    end
  end

  // history and count follow every sample transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (in_fire) begin
      if (sample_i.last_sample) begin
        count_q <= '0;
      end else if (int'(k_in) < HIST_DEPTH) begin
        count_q <= count_t'(k_in + pos_t'(1));
      end else begin
        count_q <= count_t'(HIST_DEPTH);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      for (int i = HIST_DEPTH - 1; i > 0; i--) begin
        hist_q[i] <= hist_q[i-1];
      end
      hist_q[0] <= sample_i.sample_in;
    end
  end

  // results owed by the held item and the centre of the first one
  always_comb begin
    if (last_q) begin
      base  = (int'(top_q) >= WIN_HALF) ? pos_t'(top_q - pos_t'(WIN_HALF)) : '0;
      n_res = nres_t'(top_q - base + pos_t'(1));
    end else if (int'(top_q) >= WIN_HALF) begin
      base  = pos_t'(top_q - pos_t'(WIN_HALF));
      n_res = nres_t'(1);
    end else begin
      base  = '0;
      n_res = '0;
    end
  end

  assign centre = pos_t'(base + pos_t'(idx_q));

  always_comb begin
    for (int d = 0; d < WIN_TAPS; d++) begin
      taps[d] = buf_q[tap_index(centre, d, top_q)];
    end
  end

  // rank select: ties broken by tap position, the tap of rank two is the median
  always_comb begin
    int rank;
    median = taps[0];
    for (int i = 0; i < WIN_TAPS; i++) begin
      rank = 0;
      for (int j = 0; j < WIN_TAPS; j++) begin
        if (j != i) begin
          if ((taps[j] < taps[i]) || ((taps[j] == taps[i]) && (j < i))) rank++;
        end
      end
      if (rank == WIN_HALF) median = taps[i];
    end
  end

  assign advance  = win_valid_q && (n_res != '0) && (!out_valid_q || result_o.ready);
  // an item with no result leaves at once, otherwise with its final result
  assign win_done = win_valid_q && ((n_res == '0) || (advance && (idx_q == n_res - 1'b1)));

  assign sample_i.ready = !win_valid_q || win_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (in_fire) begin
      win_valid_q <= 1'b1;
      idx_q       <= '0;
    end else if (win_done) begin
      win_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (advance) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      buf_q  <= buf_d;
      top_q  <= k_in;
      last_q <= sample_i.last_sample;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      median_q   <= median;
      last_res_q <= last_q && (idx_q == n_res - 1'b1);
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.median_out  = median_q;
  assign result_o.last_result = last_res_q;

endmodule
